// ===== src/rar_pkg.sv =====
package rar_pkg;

  localparam int OPERAND_BITS_DEF = 16;
  localparam int RES_NUM_W        = 32;
  localparam int RES_DEN_W        = 31;

  typedef enum logic [1:0] {
    FUNC_ADD,
    FUNC_SUB,
    FUNC_MUL,
    FUNC_DIV
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_GCD,
    S_DVN_GO,
    S_DVN_WAIT,
    S_DVD_GO,
    S_DVD_WAIT,
    S_FIN
  } state_t;

endpackage

// ===== src/rational_arith_reduce_unit.sv =====
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready     | in_tdata: func, a_num, a_den, b_num, b_den
// out_    | out | out_tvalid / out_tready   | out_tdata: res_num, res_den; out_tuser: den_zero
//
// One item at a time. A multiply sequence on a shared signed multiplier, then,
// for a positive denominator, a binary GCD and two restoring divisions on one
// shared divider; a zero or negative denominator skips reduction.
// in_tready is high only while idle; the next item can be taken while a result
// waits in the output register. Reset is synchronous and clears control only.
module rational_arith_reduce_unit
  import rar_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // func, a_num, a_den, b_num, b_den
  input  logic [((4*OPERAND_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // res_num, res_den, zero pad
  output logic [((RES_NUM_W+RES_DEN_W+7)/8)*8-1:0] out_tdata,
  // den_zero
  output logic                                  out_tuser
);

  localparam int NB    = OPERAND_BITS;
  localparam int OW    = NB + 1;
  localparam int NW    = 2 * NB;
  localparam int KW    = $clog2(NW + 1);
  localparam int OUT_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
  localparam int AN_LO = 2;
  localparam int AD_LO = AN_LO + NB;
  localparam int BN_LO = AD_LO + NB - 1;
  localparam int BD_LO = BN_LO + NB;

  state_t state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  func_t func_r, func_nxt;
  logic signed [NB-1:0] an_r, an_nxt, bn_r, bn_nxt;
  logic [NB-2:0] ad_r, ad_nxt, bd_r, bd_nxt;
  logic signed [NW-1:0] p_r, p_nxt, n_r, n_nxt, d_r, d_nxt;
  logic [NW-1:0] m_r, m_nxt, x_r, x_nxt, y_r, y_nxt, g_r, g_nxt, qn_r, qn_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic neg_r, neg_nxt, red_r, red_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [RES_NUM_W-1:0] res_num_r, res_num_nxt;
  logic signed [RES_DEN_W-1:0] res_den_r, res_den_nxt;
  logic den_zero_r, den_zero_nxt;

  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [2*OW-1:0] mul_p;
  logic [NW-1:0] mag_n, div_dividend, div_q;
  logic signed [NW-1:0] rn;
  logic div_start, div_busy, div_done;

  rar_div #(.W(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    case (step_r)
      2'd0: begin
        mul_a = {an_r[NB-1], an_r};
        mul_b = (func_r == FUNC_MUL) ? {bn_r[NB-1], bn_r} : {2'b00, bd_r};
      end
      2'd1: begin
        mul_a = {bn_r[NB-1], bn_r};
        mul_b = {2'b00, ad_r};
      end
      default: begin
        mul_a = {2'b00, ad_r};
        mul_b = (func_r == FUNC_DIV) ? {bn_r[NB-1], bn_r} : {2'b00, bd_r};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign mag_n        = n_r[NW-1] ? NW'(-n_r) : NW'(n_r);
  assign div_dividend = (state_r == S_DVD_GO) ? NW'(d_r) : m_r;
  assign rn           = neg_r ? $signed(-qn_r) : $signed(qn_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    func_nxt      = func_r;
    an_nxt        = an_r;
    ad_nxt        = ad_r;
    bn_nxt        = bn_r;
    bd_nxt        = bd_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    qn_nxt        = qn_r;
    neg_nxt       = neg_r;
    red_nxt       = red_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    den_zero_nxt  = den_zero_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt  = func_t'(in_tdata[1:0]);
          an_nxt    = in_tdata[AN_LO +: NB];
          ad_nxt    = in_tdata[AD_LO +: NB-1];
          bn_nxt    = in_tdata[BN_LO +: NB];
          bd_nxt    = in_tdata[BD_LO +: NB-1];
          step_nxt  = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        p_nxt    = NW'(mul_p);
        step_nxt = step_r + 1'b1;
        case (step_r)
          2'd0: ;
          2'd1: n_nxt = p_r;
          2'd2: begin
            case (func_r)
              FUNC_ADD: n_nxt = n_r + p_r;
              FUNC_SUB: n_nxt = n_r - p_r;
              default:  n_nxt = n_r;
            endcase
          end
          default: begin
            d_nxt   = p_r;
            neg_nxt = n_r[NW-1];
            m_nxt   = mag_n;
            x_nxt   = mag_n;
            y_nxt   = NW'(p_r);
            k_nxt   = '0;
            if (p_r > 0) begin
              red_nxt   = 1'b1;
              state_nxt = S_GCD;
            end else begin
              red_nxt   = 1'b0;
              state_nxt = S_FIN;
            end
          end
        endcase
      end
      S_GCD: begin
        if (x_r == '0) begin
          g_nxt     = y_r << k_r;
          state_nxt = S_DVN_GO;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r >= y_r) begin
          x_nxt = (x_r - y_r) >> 1;
        end else begin
          y_nxt = (y_r - x_r) >> 1;
        end
      end
      S_DVN_GO: begin
        div_start = 1'b1;
        state_nxt = S_DVN_WAIT;
      end
      S_DVN_WAIT: begin
        if (div_done) begin
          qn_nxt    = div_q;
          state_nxt = S_DVD_GO;
        end
      end
      S_DVD_GO: begin
        div_start = 1'b1;
        state_nxt = S_DVD_WAIT;
      end
      S_DVD_WAIT: begin
        if (div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          if (red_r) begin
            res_num_nxt = RES_NUM_W'(rn);
            res_den_nxt = RES_DEN_W'(div_q);
          end else begin
            res_num_nxt = RES_NUM_W'(n_r);
            res_den_nxt = RES_DEN_W'(d_r);
          end
          den_zero_nxt  = (d_r == '0);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    an_r       <= an_nxt;
    ad_r       <= ad_nxt;
    bn_r       <= bn_nxt;
    bd_r       <= bd_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    k_r        <= k_nxt;
    g_r        <= g_nxt;
    qn_r       <= qn_nxt;
    neg_r      <= neg_nxt;
    red_r      <= red_nxt;
    res_num_r  <= res_num_nxt;
    res_den_r  <= res_den_nxt;
    den_zero_r <= den_zero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({res_den_r, res_num_r});
  assign out_tuser  = den_zero_r;

`ifndef ASSERT_OFF
  a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_MUL && step_r == '0)
    else $error("accepted item did not start the multiply sequence");

  a_gcd_y_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GCD |-> y_r != '0)
    else $error("gcd operand y reached zero");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_den_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && den_zero_r |-> res_den_r == '0)
    else $error("den_zero set with nonzero denominator");
`endif

endmodule

// ===== src/rar_div.sv =====
module rar_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, q_nxt;
  logic [W:0]    r_r, r_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    rs;
  logic [W+1:0]  diff;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rs       = {r_r[W-1:0], q_r[W-1]};
    diff     = {1'b0, rs} - {2'b00, dsr_r};
    q_nxt    = q_r;
    r_nxt    = r_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W+1]) begin
        r_nxt = diff[W:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = rs;
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule
